/* rtl/core/swu_pkg.sv */
// Types, widths, register codes and reset values shared by the weight update block
`default_nettype none
package swu_pkg;

  localparam int DATA_W    = 32;
  localparam int STEP_W    = 31;
  localparam int NOISE_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam int DECAY_PROD_W = DATA_W + STEP_W;
  localparam int STEP_PROD_W  = 2 * STEP_W;
  localparam int NOISE_PROD_W = NOISE_W + STEP_W;
  localparam int DECAY_RND_W  = DECAY_PROD_W - FRAC_W;
  localparam int STEP_RND_W   = STEP_PROD_W - FRAC_W;
  localparam int NOISE_RND_W  = NOISE_PROD_W - FRAC_W;
  localparam int SLOPE_W      = DECAY_RND_W + 3;
  localparam int WSUM_W       = DATA_W + 1;
  localparam int NOISY_W      = STEP_RND_W + 1;

  localparam logic [FRAC_W-1:0] HALF_LSB = 16'h8000;

  localparam logic [STEP_W-1:0] STEP_ONE = 31'd1;
  localparam logic [STEP_W-1:0] STEP_MAX = 31'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN  = 32'h8000_0000;

  localparam logic [STEP_W-1:0] INC_RST       = 31'd78643;
  localparam logic [STEP_W-1:0] DEC_RST       = 31'd32768;
  localparam logic [STEP_W-1:0] STEP_MIN_RST  = 31'd1;
  localparam logic [STEP_W-1:0] STEP_MAX_RST  = 31'd3276800;
  localparam logic [STEP_W-1:0] DECAY_RST     = 31'd0;
  localparam logic [STEP_W-1:0] ERR_THR_RST   = 31'd0;
  localparam logic [STEP_W-1:0] NOISE_SC_RST  = 31'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INC,
    CFG_DEC,
    CFG_STEP_MIN,
    CFG_STEP_MAX,
    CFG_DECAY,
    CFG_ERR_THR,
    CFG_NOISE
  } cfg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0] increase_factor;
    logic [STEP_W-1:0] decrease_factor;
    logic [STEP_W-1:0] step_min;
    logic [STEP_W-1:0] step_max;
    logic [STEP_W-1:0] decay_factor;
    logic [STEP_W-1:0] error_threshold;
    logic [STEP_W-1:0] noise_scale;
  } swu_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0]       weight;
    logic [DATA_W-1:0]       gradient;
    logic [STEP_W-1:0]       prior_step;
    logic [DATA_W-1:0]       prior_slope;
    logic [NOISE_W-1:0]      noise_sample;
    logic                    last_in_sweep;
  } swu_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]       weight;
    logic [DATA_W-1:0]       gradient;
    logic [STEP_W-1:0]       pstep;
    logic                    ps_nz;
    logic                    ps_neg;
    logic                    small_step;
    logic                    last;
    logic [DECAY_PROD_W-1:0] decay_prod;
    logic [STEP_PROD_W-1:0]  inc_prod;
    logic [STEP_PROD_W-1:0]  dec_prod;
    logic [NOISE_PROD_W-1:0] noise_prod;
  } swu_s1_t;

  typedef struct packed {
    logic [DATA_W-1:0]      weight;
    logic [DATA_W-1:0]      slope;
    logic [STEP_W-1:0]      pstep;
    logic                   ps_nz;
    logic                   ps_neg;
    logic                   small_step;
    logic                   last;
    logic [STEP_W-1:0]      grown;
    logic [STEP_RND_W-1:0]  shrunk;
    logic [NOISE_RND_W-1:0] noise_term;
  } swu_s2_t;

  typedef struct packed {
    logic [DATA_W-1:0] new_weight;
    logic [STEP_W-1:0] new_step;
    logic [DATA_W-1:0] new_slope;
    logic              sweep_done;
  } swu_res_t;

endpackage
`default_nettype wire

/* rtl/core/swu_if.sv */
// Valid/ready channel interfaces: input items, results and register writes
`default_nettype none
interface swu_in_if;
  import swu_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  weight;
  logic signed [DATA_W-1:0]  gradient;
  logic [STEP_W-1:0]         prior_step;
  logic signed [DATA_W-1:0]  prior_slope;
  logic [NOISE_W-1:0]        noise_sample;
  logic                      last_in_sweep;
  modport source (output valid, weight, gradient, prior_step, prior_slope, noise_sample,
                  last_in_sweep, input ready);
  modport sink (input valid, weight, gradient, prior_step, prior_slope, noise_sample,
                last_in_sweep, output ready);
endinterface

interface swu_out_if;
  import swu_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  new_weight;
  logic [STEP_W-1:0]         new_step;
  logic signed [DATA_W-1:0]  new_slope;
  logic                      sweep_done;
  modport source (output valid, new_weight, new_step, new_slope, sweep_done, input ready);
  modport sink (input valid, new_weight, new_step, new_slope, sweep_done, output ready);
endinterface

interface swu_cfg_if;
  import swu_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [STEP_W-1:0]    data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/swu_mul.sv */
// Stage one: operand conditioning and the four fixed-point products
`default_nettype none
module swu_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              vld_i,
  input  swu_pkg::swu_item_t item_i,
  input  swu_pkg::swu_cfg_t  cfg_i,
  output logic              vld_o,
  output swu_pkg::swu_s1_t   s1_o
);
  import swu_pkg::*;

  logic              vld_r;
  swu_s1_t           s1_r;
  swu_s1_t           s1_nxt;
  logic [DATA_W-1:0] wmag;
  logic [STEP_W-1:0] pstep;

  always_comb begin
    wmag  = item_i.weight[DATA_W-1] ? (~item_i.weight + 1'b1) : item_i.weight;
    pstep = (item_i.prior_step == '0) ? STEP_ONE : item_i.prior_step;
    s1_nxt.weight     = item_i.weight;
    s1_nxt.gradient   = item_i.gradient;
    s1_nxt.pstep      = pstep;
    s1_nxt.ps_nz      = (item_i.prior_slope != '0);
    s1_nxt.ps_neg     = item_i.prior_slope[DATA_W-1];
    s1_nxt.small_step = (pstep < cfg_i.error_threshold);
    s1_nxt.last       = item_i.last_in_sweep;
    s1_nxt.decay_prod = DECAY_PROD_W'(wmag) * DECAY_PROD_W'(cfg_i.decay_factor);
    s1_nxt.inc_prod   = STEP_PROD_W'(pstep) * STEP_PROD_W'(cfg_i.increase_factor);
    s1_nxt.dec_prod   = STEP_PROD_W'(pstep) * STEP_PROD_W'(cfg_i.decrease_factor);
    s1_nxt.noise_prod = NOISE_PROD_W'(item_i.noise_sample) * NOISE_PROD_W'(cfg_i.noise_scale);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  assign vld_o = vld_r;
  assign s1_o  = s1_r;

endmodule
`default_nettype wire

/* rtl/core/swu_rnd.sv */
// Stage two: product rounding, slope formation and saturation, step growth clamp
`default_nettype none
module swu_rnd (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             vld_i,
  input  swu_pkg::swu_s1_t s1_i,
  input  swu_pkg::swu_cfg_t cfg_i,
  output logic             vld_o,
  output swu_pkg::swu_s2_t s2_o
);
  import swu_pkg::*;

  logic                      vld_r;
  swu_s2_t                   s2_r;
  swu_s2_t                   s2_nxt;
  logic [DECAY_PROD_W-1:0]   decay_sum;
  logic [STEP_PROD_W-1:0]    inc_sum;
  logic [STEP_PROD_W-1:0]    dec_sum;
  logic [NOISE_PROD_W-1:0]   noise_sum;
  logic [STEP_RND_W-1:0]     inc_rnd;
  logic signed [SLOPE_W-1:0] dmag;
  logic signed [SLOPE_W-1:0] gext;
  logic signed [SLOPE_W-1:0] slope_wide;
  logic                      slope_ovf;

  always_comb begin
    decay_sum = s1_i.decay_prod + DECAY_PROD_W'(HALF_LSB);
    inc_sum   = s1_i.inc_prod + STEP_PROD_W'(HALF_LSB);
    dec_sum   = s1_i.dec_prod + STEP_PROD_W'(HALF_LSB);
    noise_sum = s1_i.noise_prod + NOISE_PROD_W'(HALF_LSB);
    inc_rnd   = inc_sum[STEP_PROD_W-1:FRAC_W];

    dmag = $signed(SLOPE_W'(decay_sum[DECAY_PROD_W-1:FRAC_W]));
    gext = $signed({{(SLOPE_W-DATA_W){s1_i.gradient[DATA_W-1]}}, s1_i.gradient});
    slope_wide = s1_i.weight[DATA_W-1] ? (dmag - gext) : (-gext - dmag);
    slope_ovf  = (slope_wide[SLOPE_W-1:DATA_W-1] != '0) &&
                 (slope_wide[SLOPE_W-1:DATA_W-1] != '1);

    s2_nxt.weight = s1_i.weight;
    if (!slope_ovf) begin
      s2_nxt.slope = slope_wide[DATA_W-1:0];
    end else if (slope_wide[SLOPE_W-1]) begin
      s2_nxt.slope = S32_MIN;
    end else begin
      s2_nxt.slope = S32_MAX;
    end
    s2_nxt.pstep      = s1_i.pstep;
    s2_nxt.ps_nz      = s1_i.ps_nz;
    s2_nxt.ps_neg     = s1_i.ps_neg;
    s2_nxt.small_step = s1_i.small_step;
    s2_nxt.last       = s1_i.last;
    s2_nxt.grown      = (inc_rnd > STEP_RND_W'(cfg_i.step_max)) ? cfg_i.step_max
                                                                 : inc_rnd[STEP_W-1:0];
    s2_nxt.shrunk     = dec_sum[STEP_PROD_W-1:FRAC_W];
    s2_nxt.noise_term = noise_sum[NOISE_PROD_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign vld_o = vld_r;
  assign s2_o  = s2_r;

endmodule
`default_nettype wire

/* rtl/core/swu_sel.sv */
// Stage three: sign test, step and weight selection, output register
`default_nettype none
module swu_sel (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              vld_i,
  input  swu_pkg::swu_s2_t  s2_i,
  input  swu_pkg::swu_cfg_t cfg_i,
  output logic              vld_o,
  output swu_pkg::swu_res_t res_o
);
  import swu_pkg::*;

  logic                     vld_r;
  swu_res_t                 res_r;
  swu_res_t                 res_nxt;
  logic                     s_nz;
  logic                     s_neg;
  logic                     rel_pos;
  logic                     rel_neg;
  logic [STEP_W-1:0]        mv;
  logic signed [WSUM_W-1:0] wext;
  logic signed [WSUM_W-1:0] mvext;
  logic signed [WSUM_W-1:0] wsum;
  logic [DATA_W-1:0]        wsat;
  logic [NOISY_W-1:0]       noisy;
  logic [STEP_RND_W-1:0]    floored;
  logic [STEP_W-1:0]        shrink_step;

  always_comb begin
    s_nz    = (s2_i.slope != '0);
    s_neg   = s2_i.slope[DATA_W-1];
    rel_pos = s2_i.ps_nz && s_nz && (s2_i.ps_neg == s_neg);
    rel_neg = s2_i.ps_nz && s_nz && (s2_i.ps_neg != s_neg);

    mv    = rel_pos ? s2_i.grown : s2_i.pstep;
    wext  = $signed({s2_i.weight[DATA_W-1], s2_i.weight});
    mvext = $signed(WSUM_W'(mv));
    wsum  = s_neg ? (wext + mvext) : (wext - mvext);
    if (wsum[WSUM_W-1] == wsum[WSUM_W-2]) begin
      wsat = wsum[DATA_W-1:0];
    end else if (wsum[WSUM_W-1]) begin
      wsat = S32_MIN;
    end else begin
      wsat = S32_MAX;
    end

    noisy   = NOISY_W'(s2_i.shrunk) + NOISY_W'(s2_i.noise_term);
    floored = (s2_i.shrunk < STEP_RND_W'(cfg_i.step_min)) ? STEP_RND_W'(cfg_i.step_min)
                                                         : s2_i.shrunk;
    if (s2_i.small_step) begin
      shrink_step = (noisy[NOISY_W-1:STEP_W] != '0) ? STEP_MAX : noisy[STEP_W-1:0];
    end else begin
      shrink_step = (floored[STEP_RND_W-1:STEP_W] != '0) ? STEP_MAX : floored[STEP_W-1:0];
    end

    res_nxt.sweep_done = s2_i.last;
    if (rel_pos) begin
      res_nxt.new_weight = wsat;
      res_nxt.new_step   = s2_i.grown;
      res_nxt.new_slope  = s2_i.slope;
    end else if (rel_neg) begin
      res_nxt.new_weight = s2_i.weight;
      res_nxt.new_step   = shrink_step;
      res_nxt.new_slope  = '0;
    end else begin
      res_nxt.new_weight = wsat;
      res_nxt.new_step   = '0;
      res_nxt.new_slope  = s2_i.slope;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign vld_o = vld_r;
  assign res_o = res_r;

endmodule
`default_nettype wire

/* rtl/core/sarprop_weight_update.sv */
// Top level of the SARPROP per-parameter weight update pipeline
// One parameter enters per cycle whenever the sink takes results: stage one forms
// the decay and step products, stage two rounds them and saturates the new slope, stage
// three resolves the sign test, moves the weight and holds the result for the sink.
// Throughput is one item per cycle whenever the sink takes results. Ready travels back
// through the stages, so a stalled sink stops the pipe only once every stage holds an item.
// Weights and slopes are signed Q16.16 and steps unsigned Q15.16, with products rounded
// to nearest, ties away from zero, and every result field saturated. Write the registers
// only while the pipe is empty; writes to an index past the last register are dropped.
`default_nettype none
module sarprop_weight_update (
  input  logic clk,
  input  logic rst_n,
  swu_in_if.sink    in_bus,
  swu_out_if.source out_bus,
  swu_cfg_if.sink   cfg_bus
);
  import swu_pkg::*;

  swu_cfg_t  cfg_r;
  swu_item_t item;
  swu_s1_t   s1;
  swu_s2_t   s2;
  swu_res_t  res;
  logic      v1;
  logic      v2;
  logic      v3;
  logic      adv1;
  logic      adv2;
  logic      adv3;
  logic      in_acc;
  logic      out_acc;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.increase_factor <= INC_RST;
      cfg_r.decrease_factor <= DEC_RST;
      cfg_r.step_min        <= STEP_MIN_RST;
      cfg_r.step_max        <= STEP_MAX_RST;
      cfg_r.decay_factor    <= DECAY_RST;
      cfg_r.error_threshold <= ERR_THR_RST;
      cfg_r.noise_scale     <= NOISE_SC_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_idx_t'(cfg_bus.idx))
        CFG_INC:      cfg_r.increase_factor <= cfg_bus.data;
        CFG_DEC:      cfg_r.decrease_factor <= cfg_bus.data;
        CFG_STEP_MIN: cfg_r.step_min        <= cfg_bus.data;
        CFG_STEP_MAX: cfg_r.step_max        <= cfg_bus.data;
        CFG_DECAY:    cfg_r.decay_factor    <= cfg_bus.data;
        CFG_ERR_THR:  cfg_r.error_threshold <= cfg_bus.data;
        CFG_NOISE:    cfg_r.noise_scale     <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  assign adv3          = !v3 || out_bus.ready;
  assign adv2          = !v2 || adv3;
  assign adv1          = !v1 || adv2;
  assign in_bus.ready  = adv1;
  assign in_acc        = in_bus.valid && adv1;
  assign out_acc       = v3 && out_bus.ready;

  always_comb begin
    item.weight        = in_bus.weight;
    item.gradient      = in_bus.gradient;
    item.prior_step    = in_bus.prior_step;
    item.prior_slope   = in_bus.prior_slope;
    item.noise_sample  = in_bus.noise_sample;
    item.last_in_sweep = in_bus.last_in_sweep;
  end

  swu_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv1),
    .vld_i  (in_bus.valid),
    .item_i (item),
    .cfg_i  (cfg_r),
    .vld_o  (v1),
    .s1_o   (s1)
  );

  swu_rnd u_rnd (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv2),
    .vld_i (v1),
    .s1_i  (s1),
    .cfg_i (cfg_r),
    .vld_o (v2),
    .s2_o  (s2)
  );

  swu_sel u_sel (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv3),
    .vld_i (v2),
    .s2_i  (s2),
    .cfg_i (cfg_r),
    .vld_o (v3),
    .res_o (res)
  );

  assign out_bus.valid      = v3;
  assign out_bus.new_weight = res.new_weight;
  assign out_bus.new_step   = res.new_step;
  assign out_bus.new_slope  = res.new_slope;
  assign out_bus.sweep_done = res.sweep_done;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (v1 && v2 && v3))
    else $error("input blocked while the pipe has a bubble");

  a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> v1)
    else $error("accepted beat missing from stage one");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_acc) |=>
      ($countones({v1, v2, v3}) == $past($countones({v1, v2, v3})) + 1))
    else $error("occupancy did not grow on an accepted beat");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && out_acc) |=>
      ($countones({v1, v2, v3}) + 1 == $past($countones({v1, v2, v3}))))
    else $error("occupancy did not drop on a delivered beat");

endmodule
`default_nettype wire

/* tb/tb_sarprop_weight_update.sv */
// Self-checking testbench for the SARPROP weight update pipeline with scoreboard and stimulus
`timescale 1ns / 100ps
module tb_sarprop_weight_update;
  import swu_pkg::*;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 172;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 6;
  localparam int LIMIT_CYCLES    = 200000;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class update_board;
    swu_cfg_t regs;
    swu_res_t pending_updates[$];
    int mismatches;
    int checked;

    function new();
      regs = '{INC_RST, DEC_RST, STEP_MIN_RST, STEP_MAX_RST, DECAY_RST, ERR_THR_RST,
               NOISE_SC_RST};
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] value);
      case (idx)
        CFG_INC:      regs.increase_factor = value;
        CFG_DEC:      regs.decrease_factor = value;
        CFG_STEP_MIN: regs.step_min = value;
        CFG_STEP_MAX: regs.step_max = value;
        CFG_DECAY:    regs.decay_factor = value;
        CFG_ERR_THR:  regs.error_threshold = value;
        CFG_NOISE:    regs.noise_scale = value;
        default: ;
      endcase
    endfunction

    function longint round_q(longint a, longint b);
      return (a * b + longint'(HALF_LSB)) >> FRAC_W;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function int polarity(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function swu_res_t predict_update(swu_item_t it);
      longint w, g, prev_slope, wmag, decay_term, slope, nw, pstep, nstep, shrunk;
      int rel;
      swu_res_t r;
      w = longint'($signed(it.weight));
      g = longint'($signed(it.gradient));
      prev_slope = longint'($signed(it.prior_slope));
      wmag = (w < 0) ? -w : w;
      decay_term = round_q(wmag, longint'(regs.decay_factor));
      if (w < 0) decay_term = -decay_term;
      slope = clip32(-g - decay_term);
      pstep = (it.prior_step == '0) ? 64'sd1 : longint'(it.prior_step);
      nstep = 64'sd0;
      nw = w;
      rel = polarity(prev_slope) * polarity(slope);
      if (rel > 0) begin
        nstep = round_q(pstep, longint'(regs.increase_factor));
        if (nstep > longint'(regs.step_max)) nstep = longint'(regs.step_max);
        nw = (slope < 0) ? w + nstep : w - nstep;
      end else if (rel < 0) begin
        shrunk = round_q(pstep, longint'(regs.decrease_factor));
        if (pstep < longint'(regs.error_threshold)) begin
          nstep = shrunk + round_q(longint'(it.noise_sample), longint'(regs.noise_scale));
        end else if (shrunk < longint'(regs.step_min)) begin
          nstep = longint'(regs.step_min);
        end else begin
          nstep = shrunk;
        end
        if (nstep > longint'(STEP_MAX)) nstep = longint'(STEP_MAX);
        slope = 64'sd0;
      end else begin
        nw = (slope < 0) ? w + pstep : w - pstep;
      end
      nw = clip32(nw);
      r.new_weight = nw[DATA_W-1:0];
      r.new_step   = nstep[STEP_W-1:0];
      r.new_slope  = slope[DATA_W-1:0];
      r.sweep_done = it.last_in_sweep;
      return r;
    endfunction

    function void note_item(swu_item_t it);
      pending_updates.push_back(predict_update(it));
    endfunction

    function void log_mismatch(string what, swu_res_t want, swu_res_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected w=%h step=%h slope=%h done=%b", what, want.new_weight,
                 want.new_step, want.new_slope, want.sweep_done);
        $display("    actual   w=%h step=%h slope=%h done=%b", got.new_weight,
                 got.new_step, got.new_slope, got.sweep_done);
      end
    endfunction

    function void check_result(swu_res_t got);
      swu_res_t want;
      checked++;
      if (pending_updates.size() == 0) begin
        log_mismatch("result beat with no pending update", '0, got);
      end else begin
        want = pending_updates.pop_front();
        if (got.new_weight !== want.new_weight || got.new_step !== want.new_step ||
            got.new_slope !== want.new_slope || got.sweep_done !== want.sweep_done) begin
          log_mismatch("result mismatch", want, got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   in_idle_pct = 0;
  int   out_stall_pct = 0;
  bit   hold_req = 1'b0;

  update_board board = new();

  swu_in_if  in_bus();
  swu_out_if out_bus();
  swu_cfg_if cfg_bus();

  sarprop_weight_update dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin : bus_monitor
    swu_item_t it;
    swu_res_t  got;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) board.write_reg(cfg_bus.idx, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) begin
        it.weight        = in_bus.weight;
        it.gradient      = in_bus.gradient;
        it.prior_step    = in_bus.prior_step;
        it.prior_slope   = in_bus.prior_slope;
        it.noise_sample  = in_bus.noise_sample;
        it.last_in_sweep = in_bus.last_in_sweep;
        board.note_item(it);
      end
      if (out_bus.valid && out_bus.ready) begin
        got.new_weight = out_bus.new_weight;
        got.new_step   = out_bus.new_step;
        got.new_slope  = out_bus.new_slope;
        got.sweep_done = out_bus.sweep_done;
        board.check_result(got);
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    bit hold_ack;
    hold_left = 0;
    hold_ack = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready = 1'b0;
      end else begin
        out_bus.ready = ($urandom_range(0, 99) >= out_stall_pct);
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_sarprop_weight_update: FAIL");
    $finish;
  end

  function automatic swu_item_t make_item(logic [DATA_W-1:0] w, logic [DATA_W-1:0] g,
                                          logic [STEP_W-1:0] ps, logic [DATA_W-1:0] sl,
                                          logic [NOISE_W-1:0] nz, logic last);
    swu_item_t it;
    it = '{w, g, ps, sl, nz, last};
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] rand_data();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return S32_MAX;
      2: return S32_MIN;
      3: return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
      4: return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    longint near;
    case ($urandom_range(0, 6))
      0: return '0;
      1: return STEP_ONE;
      2: return STEP_MAX;
      3: begin
        near = longint'(board.regs.error_threshold) + $urandom_range(0, 4) - 2;
        if (near < 0) near = 64'sd0;
        if (near > longint'(STEP_MAX)) near = longint'(STEP_MAX);
        return near[STEP_W-1:0];
      end
      4: return STEP_W'($urandom_range(0, 32'h80_0000));
      default: return STEP_W'($urandom());
    endcase
  endfunction

  function automatic swu_item_t rand_item();
    logic [NOISE_W-1:0] nz;
    case ($urandom_range(0, 9))
      0: nz = '0;
      1: nz = '1;
      default: nz = NOISE_W'($urandom_range(0, 16'hFFFF));
    endcase
    return make_item(rand_data(), rand_data(), rand_step(), rand_data(), nz,
                     $urandom_range(0, 7) == 0);
  endfunction

  function automatic logic [STEP_W-1:0] pick_reg(logic [STEP_W-1:0] typical);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return STEP_MAX;
      2: return STEP_W'($urandom_range(0, 32'h2_0000));
      3: return STEP_W'($urandom());
      default: return STEP_W'(typical + $urandom_range(0, 255) - 128);
    endcase
  endfunction

  function automatic swu_cfg_t phase_settings(int p);
    swu_cfg_t c;
    case (p)
      1: c = '0;
      2: c = '1;
      3: c = '{31'd78643, 31'd32768, 31'd16, 31'd3276800, 31'd64, 31'd131072, 31'd65536};
      default: begin
        c.increase_factor = pick_reg(INC_RST);
        c.decrease_factor = pick_reg(DEC_RST);
        c.step_min        = pick_reg(31'd16);
        c.step_max        = pick_reg(STEP_MAX_RST);
        c.decay_factor    = pick_reg(31'd64);
        c.error_threshold = pick_reg(31'd131072);
        c.noise_scale     = pick_reg(31'd65536);
      end
    endcase
    return c;
  endfunction

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin in_idle_pct = 0;  out_stall_pct = 0;  end
      IDLE_SENDER:   begin in_idle_pct = 69; out_stall_pct = 0;  end
      IDLE_RECEIVER: begin in_idle_pct = 0;  out_stall_pct = 69; end
      IDLE_BOTH:     begin in_idle_pct = 31; out_stall_pct = 31; end
    endcase
  endtask

  task automatic send_item(swu_item_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid         = 1'b1;
    in_bus.weight        = it.weight;
    in_bus.gradient      = it.gradient;
    in_bus.prior_step    = it.prior_step;
    in_bus.prior_slope   = it.prior_slope;
    in_bus.noise_sample  = it.noise_sample;
    in_bus.last_in_sweep = it.last_in_sweep;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] value);
    cfg_bus.valid = 1'b1;
    cfg_bus.idx   = idx;
    cfg_bus.data  = value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic program_all(swu_cfg_t c);
    program_reg(CFG_INC, c.increase_factor);
    program_reg(CFG_DEC, c.decrease_factor);
    program_reg(CFG_STEP_MIN, c.step_min);
    program_reg(CFG_STEP_MAX, c.step_max);
    program_reg(CFG_DECAY, c.decay_factor);
    program_reg(CFG_ERR_THR, c.error_threshold);
    program_reg(CFG_NOISE, c.noise_scale);
  endtask

  task automatic drain_pipe();
    in_bus.valid = 1'b0;
    while (board.pending_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int p;
    int n;
    in_bus.valid         = 1'b0;
    in_bus.weight        = '0;
    in_bus.gradient      = '0;
    in_bus.prior_step    = '0;
    in_bus.prior_slope   = '0;
    in_bus.noise_sample  = '0;
    in_bus.last_in_sweep = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.idx          = '0;
    cfg_bus.data         = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_idle(IDLE_NONE);
    send_item(make_item('0, '0, '0, '0, '0, 1'b0));
    send_item(make_item('0, 32'hFFFF_0000, 31'd65536, 32'h0001_0000, 16'h1234, 1'b0));
    send_item(make_item('0, 32'h0001_0000, 31'd65536, 32'hFFFF_0000, 16'h0001, 1'b0));
    send_item(make_item(32'h0003_0000, 32'hFFFF_0000, 31'd65536, 32'hFFFF_0000, '0, 1'b0));
    send_item(make_item(32'h0000_8000, 32'hFFFF_0000, '0, 32'h0000_0001, '0, 1'b0));
    send_item(make_item('0, 32'h0000_0005, 31'd3276800, 32'h8000_0000, '0, 1'b0));
    send_item(make_item(32'h1234_5678, S32_MIN, 31'd65536, 32'h0000_0001, '0, 1'b0));
    send_item(make_item('0, S32_MAX, 31'd98304, S32_MIN, '0, 1'b0));
    send_item(make_item(S32_MAX, 32'h0001_0000, 31'd65536, 32'hFFFF_FFFF, '0, 1'b0));
    send_item(make_item(S32_MIN, 32'hFFFF_0000, 31'd65536, 32'h0000_0001, '0, 1'b0));
    send_item(make_item(32'h0001_0000, 32'h0000_0005, 31'd40000, '0, '0, 1'b0));
    send_item(make_item(32'h0001_0000, '0, 31'd40000, 32'h0000_0100, '0, 1'b0));
    send_item(make_item('0, 32'h0000_0100, STEP_MAX, 32'h0000_0100, '0, 1'b0));
    send_item(make_item(32'h0000_0001, 32'h0000_0001, 31'd7, 32'h0000_0001, '1, 1'b1));
    send_item(make_item(S32_MAX, S32_MAX, STEP_MAX, S32_MAX, '1, 1'b1));
    send_item(make_item(S32_MIN, S32_MIN, '0, S32_MIN, '0, 1'b0));

    for (p = 1; p < NUM_PHASES; p++) begin
      drain_pipe();
      program_all(phase_settings(p));
      if (p == 5) program_reg(CFG_BAD_IDX, STEP_W'($urandom()));
      set_idle(idle_mode_t'(p % 4));
      if (p == 2) begin
        send_item(make_item('0, 32'h0000_0100, STEP_MAX, 32'h0000_0100, '1, 1'b0));
        send_item(make_item('0, 32'h0000_0100, 31'd1000, 32'h0000_0100, '1, 1'b0));
        send_item(make_item(S32_MAX, '0, 31'd65536, S32_MIN, '0, 1'b0));
        send_item(make_item(S32_MIN, '0, 31'd65536, S32_MAX, '0, 1'b1));
      end
      if (p == 4) hold_req = ~hold_req;
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_item(rand_item());
    end
    drain_pipe();

    $display("Covered %0d parameter updates over %0d register settings and four idle mixes,",
             board.checked, NUM_PHASES);
    $display("with a %0d-cycle result hold-off and %0d mismatches.", HOLD_CYCLES,
             board.mismatches);
    if (board.mismatches == 0 && board.pending_updates.size() == 0) begin
      $display("tb_sarprop_weight_update: PASS");
    end else begin
      $display("tb_sarprop_weight_update: FAIL");
    end
    $finish;
  end

endmodule
